// File: rtl/counter_priority_task_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the counter-priority task scheduler
// Shared forms for concurrent checks, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_TOP_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication.
`define CPS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Types, constants and helpers shared by the task scheduler modules.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int TASK_SLOTS = 64;
    localparam int SLOT_IDX_W = $clog2(TASK_SLOTS);
    localparam int PRIO_W     = 16;
    localparam int INDEX_W    = 6;
    localparam int STATUS_W   = 2;

    localparam logic [SLOT_IDX_W-1:0] FIRST_SLOT = SLOT_IDX_W'(0);
    localparam logic [SLOT_IDX_W-1:0] LAST_SLOT  = SLOT_IDX_W'(TASK_SLOTS - 1);

    localparam logic OP_CREATE   = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_RUNNABLE = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [PRIO_W-1:0] priority_req;
    } sched_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  task_index;
        logic [STATUS_W-1:0] status;
    } sched_rsp_t;

    // One task slot as it travels around the ring.
    typedef struct packed {
        logic              running;
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] count;
    } slot_rec_t;

    // Sequencer to ring: rotate enable and the record entering the tail cell.
    typedef struct packed {
        logic      shift;
        slot_rec_t tail;
    } ring_ctl_t;

    // Report a slot index modulo 64.
    function automatic logic [INDEX_W-1:0] to_task_index(input logic [SLOT_IDX_W-1:0] idx);
        logic [SLOT_IDX_W+INDEX_W-1:0] wide;
        wide = {{INDEX_W{1'b0}}, idx};
        return wide[INDEX_W-1:0];
    endfunction

    // Refill: (count >> 1) + prio, saturating.
    function automatic logic [PRIO_W-1:0] refill_count(input logic [PRIO_W-1:0] count,
                                                       input logic [PRIO_W-1:0] prio);
        logic [PRIO_W:0] sum;
        sum = {1'b0, count >> 1} + {1'b0, prio};
        return sum[PRIO_W] ? {PRIO_W{1'b1}} : sum[PRIO_W-1:0];
    endfunction

endpackage

// File: rtl/cps_cell.sv
// ----------------------------------------------------------------------------
// cps_cell
// One slot record of the ring; loads its neighbor's record on each shift.
// ----------------------------------------------------------------------------
module cps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  cps_pkg::slot_rec_t  rec_in,
    output cps_pkg::slot_rec_t  rec_out
);

    logic                       running_reg;
    logic [cps_pkg::PRIO_W-1:0] prio_reg;
    logic [cps_pkg::PRIO_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
        end
        else if (shift)
        begin
            running_reg <= rec_in.running;
        end
    end

    // Priority and counter are written before they are ever read.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            prio_reg  <= rec_in.prio;
            count_reg <= rec_in.count;
        end
    end

    assign rec_out = '{running: running_reg, prio: prio_reg, count: count_reg};

endmodule

// File: rtl/cps_seq.sv
// ----------------------------------------------------------------------------
// cps_seq
// Request sequencer: sweeps the ring head once per pass and builds the result.
// ----------------------------------------------------------------------------
module cps_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  cps_pkg::sched_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output cps_pkg::sched_rsp_t  rsp,
    input  cps_pkg::slot_rec_t   head,
    output cps_pkg::ring_ctl_t   ring_ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CREATE = 3'd1;
    localparam logic [2:0] S_PICK   = 3'd2;
    localparam logic [2:0] S_REFILL = 3'd3;
    localparam logic [2:0] S_DECR   = 3'd4;
    localparam logic [2:0] S_PUSH   = 3'd5;

    logic [2:0]                     state_reg,    state_next;
    logic [cps_pkg::SLOT_IDX_W-1:0] pos_reg,      pos_next;
    logic                           found_reg,    found_next;
    logic [cps_pkg::SLOT_IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [cps_pkg::PRIO_W-1:0]     best_cnt_reg, best_cnt_next;
    logic [cps_pkg::PRIO_W-1:0]     prio_reg,     prio_next;
    cps_pkg::sched_rsp_t            res_reg,      res_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    cps_pkg::sched_rsp_t            rsp_reg,      rsp_next;

    logic                       last;
    logic                       user_slot;
    logic [cps_pkg::PRIO_W-1:0] refilled;

    assign last      = (pos_reg == cps_pkg::LAST_SLOT);
    assign user_slot = (pos_reg != cps_pkg::FIRST_SLOT);
    assign refilled  = cps_pkg::refill_count(head.count, head.prio);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_cnt_next  = best_cnt_reg;
        prio_next      = prio_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ring_ctl.shift = 1'b0;
        ring_ctl.tail  = head;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pos_next      = cps_pkg::FIRST_SLOT;
                    found_next    = 1'b0;
                    best_idx_next = cps_pkg::FIRST_SLOT;
                    best_cnt_next = '0;
                    prio_next     = req.priority_req;
                    res_next.task_index = '0;
                    if (req.operation == cps_pkg::OP_CREATE)
                    begin
                        res_next.status = cps_pkg::ST_POOL_FULL;
                        state_next      = S_CREATE;
                    end
                    else
                    begin
                        res_next.status = cps_pkg::ST_NONE_RUNNABLE;
                        state_next      = S_PICK;
                    end
                end
            end
            S_CREATE:
            begin
                ring_ctl.shift = 1'b1;
                // Claim the first stopped user slot that passes the head.
                if (!found_reg && user_slot && !head.running)
                begin
                    ring_ctl.tail = '{running: 1'b1, prio: prio_reg, count: prio_reg};
                    found_next    = 1'b1;
                    res_next      = '{task_index: cps_pkg::to_task_index(pos_reg),
                                      status: cps_pkg::ST_OK};
                end
                pos_next = last ? cps_pkg::FIRST_SLOT : pos_reg + 1'b1;
                if (last)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PICK:
            begin
                ring_ctl.shift = 1'b1;
                if (user_slot && head.running && head.count > best_cnt_reg)
                begin
                    best_cnt_next = head.count;
                    best_idx_next = pos_reg;
                end
                pos_next = last ? cps_pkg::FIRST_SLOT : pos_reg + 1'b1;
                if (last)
                begin
                    state_next = (best_idx_next != cps_pkg::FIRST_SLOT) ? S_DECR : S_REFILL;
                end
            end
            S_REFILL:
            begin
                ring_ctl.shift = 1'b1;
                // Refill and pick again in the same sweep.
                if (user_slot && head.running)
                begin
                    ring_ctl.tail.count = refilled;
                    if (refilled > best_cnt_reg)
                    begin
                        best_cnt_next = refilled;
                        best_idx_next = pos_reg;
                    end
                end
                pos_next = last ? cps_pkg::FIRST_SLOT : pos_reg + 1'b1;
                if (last)
                begin
                    state_next = (best_idx_next != cps_pkg::FIRST_SLOT) ? S_DECR : S_PUSH;
                end
            end
            S_DECR:
            begin
                ring_ctl.shift = 1'b1;
                if (pos_reg == best_idx_reg)
                begin
                    ring_ctl.tail.count = head.count - 1'b1;
                end
                pos_next = last ? cps_pkg::FIRST_SLOT : pos_reg + 1'b1;
                if (last)
                begin
                    res_next   = '{task_index: cps_pkg::to_task_index(best_idx_reg),
                                   status: cps_pkg::ST_OK};
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                // Hold until the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= cps_pkg::FIRST_SLOT;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_cnt_reg <= best_cnt_next;
        prio_reg     <= prio_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

endmodule

// File: rtl/counter_priority_task_scheduler_top.sv
// Create makes one full rotation of the ring. Schedule makes a pick rotation and then a
// decrement rotation, with a refill rotation between them when the pick finds no runnable
// slot; if the refill finds none either, no decrement follows. A stalled result waits in push.
// One request at a time: the next is taken in the cycle after the result is registered.
// Reset (async, rst_n low) stops every slot; the sequencer returns to idle, output empty.
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_top
// Task table held as a rotating ring of slot cells with one sequencer at the head.
// ----------------------------------------------------------------------------
`include "counter_priority_task_scheduler_top_macros.svh"

module counter_priority_task_scheduler_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  cps_pkg::sched_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output cps_pkg::sched_rsp_t  rsp
);

    // Ring: cell i hands its record to cell i-1 on every shift; cell 0 is the
    // head that the sequencer inspects, and the sequencer's possibly modified
    // copy of the head enters the last cell. A pass is exactly TASK_SLOTS
    // shifts, so every slot returns to its home cell at the end of a pass and
    // the sequencer's position counter names the slot at the head.
    cps_pkg::slot_rec_t ring [cps_pkg::TASK_SLOTS];
    cps_pkg::ring_ctl_t ring_ctl;

    genvar gi;
    generate
        for (gi = 0; gi < cps_pkg::TASK_SLOTS; gi++)
        begin : g_cell
            if (gi == cps_pkg::TASK_SLOTS - 1)
            begin : g_tail
                cps_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (ring_ctl.shift),
                    .rec_in  (ring_ctl.tail),
                    .rec_out (ring[gi])
                );
            end
            else
            begin : g_body
                cps_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (ring_ctl.shift),
                    .rec_in  (ring[gi+1]),
                    .rec_out (ring[gi])
                );
            end
        end
    endgenerate

    // Sequencer: create claims the first stopped slot 1 upward; schedule picks
    // the largest nonzero counter (lowest index on ties), refilling once with
    // (count >> 1) + priority when none is found, then decrements the winner.
    // Slot 0 is the kernel task: the sequencer never creates into or picks it.
    cps_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .head      (ring[0]),
        .ring_ctl  (ring_ctl)
    );

    // Checks: the ring only rotates while a request is in flight, a request
    // makes the block busy on the next cycle, and failures report index zero.
    logic rsp_fail;
    assign rsp_fail = (rsp.status == cps_pkg::ST_POOL_FULL)
                   || (rsp.status == cps_pkg::ST_NONE_RUNNABLE);

    `CPS_ASSERT_IMPLY(a_shift_busy, ring_ctl.shift, !req_ready, "ring rotates while idle")
    `CPS_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, !req_ready, "not busy after request")
    `CPS_ASSERT_IMPLY(a_fail_index, rsp_valid && rsp_fail, rsp.task_index == '0, "failure index")

endmodule
